FILE: hw/rtl/etcd_pkg.sv
package etcd_pkg;

   // Frame classes, as reported on the result channel
   typedef enum logic [1:0] {
      CLS_UNKNOWN = 2'd0,
      CLS_NEUTRAL = 2'd1,
      CLS_HAPPY   = 2'd2,
      CLS_SAD     = 2'd3
   } etcd_class_type;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W = 3;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_FACE_CONF = 3'd0,
      CSR_LOWER_DELTA   = 3'd1,
      CSR_CONTRAST_MIN  = 3'd2,
      CSR_MOUTH_MARGIN  = 3'd3,
      CSR_BROAD_MIN     = 3'd4,
      CSR_SAD_LIMITS    = 3'd5,
      CSR_FRAME_COUNTS  = 3'd6
   } etcd_csr_idx_type;

   localparam int unsigned CSR_DATA_W = 24;
   localparam int unsigned CNT_W      = 32;

   // Unpacked view of all threshold settings
   typedef struct packed {
      logic [7:0] min_conf;
      logic [7:0] delta;
      logic [7:0] min_overall;
      logic [7:0] min_lower;
      logic [7:0] min_mouth;
      logic [7:0] marg_upper;
      logic [7:0] marg_lower;
      logic [7:0] broad_upper;
      logic [7:0] broad_lower;
      logic [7:0] broad_mouth;
      logic [7:0] sad_luma;
      logic [7:0] sad_contrast;
      logic [7:0] nn_confirm;
      logic [7:0] n_confirm;
      logic [7:0] hold;
   } etcd_cfg_type;

   localparam etcd_cfg_type CFG_RESET = '{
      nn_confirm: 8'd3,
      n_confirm:  8'd3,
      default:    8'd0
   };

   // One frame's feature record
   typedef struct packed {
      logic       face_present;
      logic       features_valid;
      logic [7:0] face_confidence;
      logic [7:0] avg_luma;
      logic [7:0] face_contrast;
      logic [7:0] top_luma;
      logic [7:0] bottom_luma;
      logic [7:0] top_contrast;
      logic [7:0] bottom_contrast;
      logic [7:0] lip_contrast;
   } etcd_item_type;

   // Classifier verdict for one frame
   typedef struct packed {
      etcd_class_type raw;
      logic           invalid;
   } etcd_verdict_type;

   // Saturating tallies
   typedef struct packed {
      logic [CNT_W-1:0] classify_total;
      logic [CNT_W-1:0] happy_total;
      logic [CNT_W-1:0] neutral_total;
      logic [CNT_W-1:0] sad_total;
      logic [CNT_W-1:0] unknown_total;
   } etcd_totals_type;

endpackage

FILE: hw/rtl/etcd_if.sv
// Frame feature channel
interface etcd_req_if;
   logic       valid;
   logic       ready;
   logic       face_present;
   logic       features_valid;
   logic [7:0] face_confidence;
   logic [7:0] avg_luma;
   logic [7:0] face_contrast;
   logic [7:0] top_luma;
   logic [7:0] bottom_luma;
   logic [7:0] top_contrast;
   logic [7:0] bottom_contrast;
   logic [7:0] lip_contrast;

   modport source (
      output valid, face_present, features_valid, face_confidence, avg_luma,
             face_contrast, top_luma, bottom_luma, top_contrast,
             bottom_contrast, lip_contrast,
      input  ready
   );
   modport sink (
      input  valid, face_present, features_valid, face_confidence, avg_luma,
             face_contrast, top_luma, bottom_luma, top_contrast,
             bottom_contrast, lip_contrast,
      output ready
   );
endinterface

// Classification result channel
interface etcd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  expression;
   logic [1:0]                  frame_class;
   logic                        input_invalid;
   logic [etcd_pkg::CNT_W-1:0]  classify_total;
   logic [etcd_pkg::CNT_W-1:0]  happy_total;
   logic [etcd_pkg::CNT_W-1:0]  neutral_total;
   logic [etcd_pkg::CNT_W-1:0]  sad_total;
   logic [etcd_pkg::CNT_W-1:0]  unknown_total;

   modport source (
      output valid, expression, frame_class, input_invalid, classify_total,
             happy_total, neutral_total, sad_total, unknown_total,
      input  ready
   );
   modport sink (
      input  valid, expression, frame_class, input_invalid, classify_total,
             happy_total, neutral_total, sad_total, unknown_total,
      output ready
   );
endinterface

// Register write channel
interface etcd_csr_if;
   logic                              valid;
   logic                              ready;
   logic [etcd_pkg::CSR_IDX_W-1:0]    index;
   logic [etcd_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/etcd_classify.sv
// Threshold rules: one frame record to a raw class
module etcd_classify (
   input  etcd_pkg::etcd_item_type    item,
   input  etcd_pkg::etcd_cfg_type     cfg,
   output etcd_pkg::etcd_verdict_type verdict
);

   logic       invalid;
   logic       confident;
   logic       dark;
   logic       bright;
   logic       expressive;
   logic       lower_detail;
   logic       lip_detail;
   logic       prominent;
   logic       broad;
   logic       changed;
   logic       happy;
   logic       sad;
   logic [8:0] upper_plus_marg;
   logic [8:0] lower_plus_marg;
   logic [8:0] lower_min_plus_delta;

   assign invalid = !(item.face_present && item.features_valid);

   // 9-bit sums so the margin compares cannot wrap
   assign upper_plus_marg      = {1'b0, item.top_contrast} + {1'b0, cfg.marg_upper};
   assign lower_plus_marg      = {1'b0, item.bottom_contrast} + {1'b0, cfg.marg_lower};
   assign lower_min_plus_delta = {1'b0, cfg.min_lower} + {1'b0, cfg.delta};

   // Individual rule terms
   assign confident    = item.face_confidence >= cfg.min_conf;
   assign dark         = (item.top_luma >= item.bottom_luma) &&
                         ((item.top_luma - item.bottom_luma) >= cfg.delta);
   assign bright       = (item.bottom_luma >= item.top_luma) &&
                         ((item.bottom_luma - item.top_luma) >= cfg.delta);
   assign expressive   = item.face_contrast >= cfg.min_overall;
   assign lower_detail = item.bottom_contrast >= cfg.min_lower;
   assign lip_detail   = item.lip_contrast >= cfg.min_mouth;
   assign prominent    = ({1'b0, item.lip_contrast} >= upper_plus_marg) &&
                         ({1'b0, item.lip_contrast} >= lower_plus_marg);
   assign broad        = (item.top_contrast >= cfg.broad_upper) &&
                         (item.bottom_contrast >= cfg.broad_lower) &&
                         (item.lip_contrast >= cfg.broad_mouth);
   assign changed      = dark || bright ||
                         ({1'b0, item.bottom_contrast} >= lower_min_plus_delta);

   // Happy has the mouth-prominence path and the broad-smile path
   assign happy = confident && expressive && lower_detail &&
                  ((lip_detail && prominent && changed) || broad);
   assign sad   = (item.avg_luma <= cfg.sad_luma) &&
                  (item.face_contrast <= cfg.sad_contrast);

   // Happy wins over sad; missing face or features gives unknown
   always_comb begin
      verdict.invalid = invalid;
      priority if (invalid) begin
         verdict.raw = etcd_pkg::CLS_UNKNOWN;
      end else if (happy) begin
         verdict.raw = etcd_pkg::CLS_HAPPY;
      end else if (sad) begin
         verdict.raw = etcd_pkg::CLS_SAD;
      end else begin
         verdict.raw = etcd_pkg::CLS_NEUTRAL;
      end
   end

endmodule

FILE: hw/rtl/etcd_debounce.sv
// Class debouncer and saturating tallies, updated once per item
module etcd_debounce (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  etcd_pkg::etcd_class_type  raw,
   input  etcd_pkg::etcd_cfg_type    cfg,
   output etcd_pkg::etcd_class_type  stable,
   output etcd_pkg::etcd_totals_type totals
);

   etcd_pkg::etcd_class_type  stable_ff, stable_in;
   etcd_pkg::etcd_class_type  cand_ff, cand_in;
   logic [7:0]                frames_ff, frames_in;
   logic [7:0]                hold_ff, hold_in;
   etcd_pkg::etcd_totals_type totals_ff, totals_in;
   logic [7:0]                frames_bump;
   logic [7:0]                hold_next;
   logic [8:0]                hold_plus_one;

   function automatic logic [etcd_pkg::CNT_W-1:0] sat_inc(
      input logic [etcd_pkg::CNT_W-1:0] v,
      input logic                       en
   );
      logic [etcd_pkg::CNT_W-1:0] r;
      r = v;
      if (en && (v != '1)) begin
         r = v + 1'b1;
      end
      return r;
   endfunction

   // Candidate count after this frame, saturating at 255
   assign frames_bump   = (cand_ff != raw) ? 8'd1 :
                          ((frames_ff == 8'hFF) ? frames_ff : frames_ff + 8'd1);
   assign hold_next     = hold_ff + 8'd1;
   assign hold_plus_one = {1'b0, hold_ff} + 9'd1;

   // Debounce next state
   always_comb begin
      stable_in = stable_ff;
      cand_in   = cand_ff;
      frames_in = frames_ff;
      hold_in   = hold_ff;
      if (step) begin
         priority if (raw == etcd_pkg::CLS_UNKNOWN) begin
            stable_in = etcd_pkg::CLS_UNKNOWN;
            cand_in   = etcd_pkg::CLS_UNKNOWN;
            frames_in = 8'd0;
            hold_in   = 8'd0;
         end else if (stable_ff == etcd_pkg::CLS_UNKNOWN) begin
            // leaving unknown always reports neutral first
            stable_in = etcd_pkg::CLS_NEUTRAL;
            hold_in   = 8'd0;
            if (raw != etcd_pkg::CLS_NEUTRAL) begin
               cand_in   = raw;
               frames_in = 8'd1;
            end else begin
               cand_in   = etcd_pkg::CLS_UNKNOWN;
               frames_in = 8'd0;
            end
         end else if (raw == stable_ff) begin
            cand_in   = etcd_pkg::CLS_UNKNOWN;
            frames_in = 8'd0;
            hold_in   = 8'd0;
         end else if (raw == etcd_pkg::CLS_NEUTRAL) begin
            // hold the old class, then require the neutral confirm count
            priority if (hold_ff < cfg.hold) begin
               hold_in = hold_next;
            end else if (hold_plus_one < {1'b0, cfg.n_confirm}) begin
               hold_in   = hold_next;
               cand_in   = etcd_pkg::CLS_NEUTRAL;
               frames_in = 8'd0;
            end else begin
               stable_in = etcd_pkg::CLS_NEUTRAL;
               cand_in   = etcd_pkg::CLS_UNKNOWN;
               frames_in = 8'd0;
               hold_in   = 8'd0;
            end
         end else begin
            // happy or sad differing from stable
            frames_in = frames_bump;
            if (cand_ff != raw) begin
               cand_in = raw;
               hold_in = 8'd0;
            end
            if (frames_bump >= cfg.nn_confirm) begin
               stable_in = raw;
               cand_in   = etcd_pkg::CLS_UNKNOWN;
               frames_in = 8'd0;
               hold_in   = 8'd0;
            end
         end
      end
   end

   // Tallies follow the debounced class of this frame
   always_comb begin
      totals_in.classify_total = sat_inc(totals_ff.classify_total, step);
      totals_in.happy_total    = sat_inc(totals_ff.happy_total,
                                         step && (stable_in == etcd_pkg::CLS_HAPPY));
      totals_in.neutral_total  = sat_inc(totals_ff.neutral_total,
                                         step && (stable_in == etcd_pkg::CLS_NEUTRAL));
      totals_in.sad_total      = sat_inc(totals_ff.sad_total,
                                         step && (stable_in == etcd_pkg::CLS_SAD));
      totals_in.unknown_total  = sat_inc(totals_ff.unknown_total,
                                         step && (stable_in == etcd_pkg::CLS_UNKNOWN));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= etcd_pkg::CLS_UNKNOWN;
         cand_ff   <= etcd_pkg::CLS_UNKNOWN;
         frames_ff <= 8'd0;
         hold_ff   <= 8'd0;
         totals_ff <= '0;
      end else begin
         stable_ff <= stable_in;
         cand_ff   <= cand_in;
         frames_ff <= frames_in;
         hold_ff   <= hold_in;
         totals_ff <= totals_in;
      end
   end

   assign stable = stable_ff;
   assign totals = totals_ff;

`ifndef NO_ASSERTIONS
   // Per-class tallies never pass the overall tally
   assert property (@(posedge clock) disable iff (reset)
      (totals_ff.happy_total <= totals_ff.classify_total) &&
      (totals_ff.neutral_total <= totals_ff.classify_total) &&
      (totals_ff.sad_total <= totals_ff.classify_total) &&
      (totals_ff.unknown_total <= totals_ff.classify_total))
      else $error("class tally exceeds classification tally");

   // Unknown stable class carries no candidate
   assert property (@(posedge clock) disable iff (reset)
      (stable_ff == etcd_pkg::CLS_UNKNOWN) |->
      ((cand_ff == etcd_pkg::CLS_UNKNOWN) && (frames_ff == 8'd0) && (hold_ff == 8'd0)))
      else $error("candidate state left while stable class is unknown");

   // A counted candidate is always happy or sad
   assert property (@(posedge clock) disable iff (reset)
      (frames_ff != 8'd0) |->
      ((cand_ff == etcd_pkg::CLS_HAPPY) || (cand_ff == etcd_pkg::CLS_SAD)))
      else $error("candidate count on a non-expressive class");

   // An invalid frame resets the debouncer
   assert property (@(posedge clock) disable iff (reset)
      (step && (raw == etcd_pkg::CLS_UNKNOWN)) |=> (stable_ff == etcd_pkg::CLS_UNKNOWN))
      else $error("unknown frame did not clear stable class");

   // Tallies move only when an item is processed
   assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(totals_ff))
      else $error("tallies changed without an item");
`endif

endmodule

FILE: hw/rtl/expression_threshold_classifier_debounce.sv
// Channel   Port     Dir  Payload
// -------   ------   ---  ---------------------------------------------------
// request   req_bus  in   face/feature flags, confidence, luma and contrast
// response  rsp_bus  out  debounced and raw class, invalid flag, five tallies
// csr       csr_bus  in   3-bit register index, 24-bit write data
//
// One item per clock sustained while rsp_bus is ready; an item accepted on
// req_bus enters the input register, then moves to the result register, from
// which it leaves on rsp_bus.
// The path between them is the threshold compares plus the debounce and
// 32-bit tally update.
// Sync reset clears both stages, debounce state, tallies; csrs to defaults.
// A stalled response holds its item; the input stage still fills behind it.
module expression_threshold_classifier_debounce (
   input logic        clock,
   input logic        reset,
   etcd_req_if.sink   req_bus,
   etcd_rsp_if.source rsp_bus,
   etcd_csr_if.sink   csr_bus
);

   etcd_pkg::etcd_cfg_type     cfg_ff;
   logic                       s1_valid_ff;
   etcd_pkg::etcd_item_type    s1_item_ff;
   logic                       out_valid_ff;
   etcd_pkg::etcd_class_type   raw_ff;
   logic                       invalid_ff;
   logic                       advance;
   etcd_pkg::etcd_verdict_type verdict;
   etcd_pkg::etcd_class_type   stable;
   etcd_pkg::etcd_totals_type  totals;

   // Register writes
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= etcd_pkg::CFG_RESET;
      end else if (csr_bus.valid) begin
         unique case (etcd_pkg::etcd_csr_idx_type'(csr_bus.index))
            etcd_pkg::CSR_MIN_FACE_CONF: begin
               cfg_ff.min_conf <= csr_bus.data[7:0];
            end
            etcd_pkg::CSR_LOWER_DELTA: begin
               cfg_ff.delta <= csr_bus.data[7:0];
            end
            etcd_pkg::CSR_CONTRAST_MIN: begin
               cfg_ff.min_overall <= csr_bus.data[7:0];
               cfg_ff.min_lower   <= csr_bus.data[15:8];
               cfg_ff.min_mouth   <= csr_bus.data[23:16];
            end
            etcd_pkg::CSR_MOUTH_MARGIN: begin
               cfg_ff.marg_upper <= csr_bus.data[7:0];
               cfg_ff.marg_lower <= csr_bus.data[15:8];
            end
            etcd_pkg::CSR_BROAD_MIN: begin
               cfg_ff.broad_upper <= csr_bus.data[7:0];
               cfg_ff.broad_lower <= csr_bus.data[15:8];
               cfg_ff.broad_mouth <= csr_bus.data[23:16];
            end
            etcd_pkg::CSR_SAD_LIMITS: begin
               cfg_ff.sad_luma     <= csr_bus.data[7:0];
               cfg_ff.sad_contrast <= csr_bus.data[15:8];
            end
            etcd_pkg::CSR_FRAME_COUNTS: begin
               cfg_ff.nn_confirm <= csr_bus.data[7:0];
               cfg_ff.n_confirm  <= csr_bus.data[15:8];
               cfg_ff.hold       <= csr_bus.data[23:16];
            end
            default: begin
               // unmapped index: ignored
            end
         endcase
      end
   end

   // Item moves from input register to result register
   assign advance       = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_item_ff.face_present    <= req_bus.face_present;
         s1_item_ff.features_valid  <= req_bus.features_valid;
         s1_item_ff.face_confidence <= req_bus.face_confidence;
         s1_item_ff.avg_luma        <= req_bus.avg_luma;
         s1_item_ff.face_contrast   <= req_bus.face_contrast;
         s1_item_ff.top_luma        <= req_bus.top_luma;
         s1_item_ff.bottom_luma     <= req_bus.bottom_luma;
         s1_item_ff.top_contrast    <= req_bus.top_contrast;
         s1_item_ff.bottom_contrast <= req_bus.bottom_contrast;
         s1_item_ff.lip_contrast    <= req_bus.lip_contrast;
      end
   end

   etcd_classify u_classify (
      .item    (s1_item_ff),
      .cfg     (cfg_ff),
      .verdict (verdict)
   );

   // Debounce state and tallies double as the result register's class fields
   etcd_debounce u_debounce (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .raw    (verdict.raw),
      .cfg    (cfg_ff),
      .stable (stable),
      .totals (totals)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         raw_ff     <= verdict.raw;
         invalid_ff <= verdict.invalid;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.expression     = stable;
   assign rsp_bus.frame_class    = raw_ff;
   assign rsp_bus.input_invalid  = invalid_ff;
   assign rsp_bus.classify_total = totals.classify_total;
   assign rsp_bus.happy_total    = totals.happy_total;
   assign rsp_bus.neutral_total  = totals.neutral_total;
   assign rsp_bus.sad_total      = totals.sad_total;
   assign rsp_bus.unknown_total  = totals.unknown_total;

`ifndef NO_ASSERTIONS
   // Invalid flag and unknown raw class go together
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (invalid_ff == (raw_ff == etcd_pkg::CLS_UNKNOWN)))
      else $error("invalid flag disagrees with raw class");

   // Unknown raw result always reports unknown expression
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && invalid_ff) |-> (stable == etcd_pkg::CLS_UNKNOWN))
      else $error("invalid item reported a known expression");

   // A pending input item moves on whenever the result register frees up
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (!out_valid_ff || rsp_bus.ready)) |=> out_valid_ff)
      else $error("input stage item was lost");
`endif

endmodule
